// ===== rtl/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types, op codes and word encoders for the bit row scan unit.
// ----------------------------------------------------------------------------
package brs_pkg;

    localparam int OP_W      = 3;
    localparam int WIDX_W    = 6;
    localparam int DATA_W    = 64;
    localparam int POS_W     = 12;
    localparam int BIDX_W    = 12;
    localparam int MAX_WB    = 64;
    localparam int ENC_W     = 6;

    localparam int WORD_BITS_DEF = 64;
    localparam int ROW_WORDS_DEF = 64;

    localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_NEXT  = 3'd1;
    localparam logic [OP_W-1:0] OP_PREV  = 3'd2;
    localparam logic [OP_W-1:0] OP_FIRST = 3'd3;
    localparam logic [OP_W-1:0] OP_LAST  = 3'd4;

    typedef struct packed {
        logic start;
        logic wr;
        logic scan;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic done;
    } sts_t;

    function automatic logic [ENC_W-1:0] low_one(input logic [MAX_WB-1:0] w);
        logic [ENC_W-1:0] r;
        r = '0;
        for (int i = MAX_WB - 1; i >= 0; i--) begin
            if (w[i]) begin
                r = ENC_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [ENC_W-1:0] high_one(input logic [MAX_WB-1:0] w);
        logic [ENC_W-1:0] r;
        r = '0;
        for (int i = 0; i < MAX_WB; i++) begin
            if (w[i]) begin
                r = ENC_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/bit_row_set_bit_scan_unit.sv =====
// ----------------------------------------------------------------------------
// bit_row_set_bit_scan_unit
// Bit row of ROW_WORDS words with first/next/prev/last set-bit queries.
// ----------------------------------------------------------------------------
// The row is cleared at reset (per-word valid flags, no clearing pass). A
// write transfer stores one word and returns nothing. A query transfer
// returns one result; the row RAM is read one word per cycle in scan order
// (ascending for first/next, descending for prev/last) and the scan stops at
// the first word holding a qualifying bit. The unit takes no new transfer
// until a query's result is loaded into the output register. A finished
// result waits in the output register while the next transfer is taken.
// ----------------------------------------------------------------------------
module bit_row_set_bit_scan_unit #(
    parameter int WORD_BITS = brs_pkg::WORD_BITS_DEF,
    parameter int ROW_WORDS = brs_pkg::ROW_WORDS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [brs_pkg::OP_W-1:0]     s_op,
    input  logic [brs_pkg::WIDX_W-1:0]   s_word_index,
    input  logic [brs_pkg::DATA_W-1:0]   s_word_data,
    input  logic [brs_pkg::POS_W-1:0]    s_position,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_found,
    output logic [brs_pkg::BIDX_W-1:0]   m_bit_index
);
    import brs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    brs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    brs_dp #(
        .WORD_BITS (WORD_BITS),
        .ROW_WORDS (ROW_WORDS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_op         (s_op),
        .s_word_index (s_word_index),
        .s_word_data  (s_word_data),
        .s_position   (s_position),
        .m_found      (m_found),
        .m_bit_index  (m_bit_index),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

// ===== rtl/brs_ram.sv =====
// ----------------------------------------------------------------------------
// brs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/brs_ctrl.sv =====
// ----------------------------------------------------------------------------
// brs_ctrl
// Sequencer: takes items, runs the word scan, hands the result to the output.
// ----------------------------------------------------------------------------
module brs_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [brs_pkg::OP_W-1:0] s_op,
    output logic                     m_valid,
    input  logic                     m_ready,
    output brs_pkg::cmd_t            cmd,
    input  brs_pkg::sts_t            sts
);
    import brs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       is_query;

    always_comb begin
        unique case (s_op) inside
            OP_NEXT, OP_PREV, OP_FIRST, OP_LAST: is_query = 1'b1;
            default:                             is_query = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (is_query) begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end else if (s_op == OP_WRITE) begin
                        cmd.wr = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_load_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an untaken result");

    a_start_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> (state_reg == ST_SCAN))
        else $error("query start did not enter scan");

endmodule

// ===== rtl/brs_dp.sv =====
// ----------------------------------------------------------------------------
// brs_dp
// Row storage and word scan datapath: one row word read per cycle, masked
// against the query bound and priority encoded.
// ----------------------------------------------------------------------------
module brs_dp #(
    parameter int WORD_BITS = brs_pkg::WORD_BITS_DEF,
    parameter int ROW_WORDS = brs_pkg::ROW_WORDS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [brs_pkg::OP_W-1:0]     s_op,
    input  logic [brs_pkg::WIDX_W-1:0]   s_word_index,
    input  logic [brs_pkg::DATA_W-1:0]   s_word_data,
    input  logic [brs_pkg::POS_W-1:0]    s_position,
    output logic                         m_found,
    output logic [brs_pkg::BIDX_W-1:0]   m_bit_index,
    input  brs_pkg::cmd_t                cmd,
    output brs_pkg::sts_t                sts
);
    import brs_pkg::*;

    localparam int ROW_BITS = WORD_BITS * ROW_WORDS;
    localparam int CW_ROW   = $clog2(ROW_BITS + 1);
    localparam int CW       = (CW_ROW > POS_W + 1) ? CW_ROW : POS_W + 1;
    localparam int LI_W     = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int WR_WORDS = (ROW_WORDS < (1 << WIDX_W)) ? ROW_WORDS : (1 << WIDX_W);
    localparam int AW       = (WR_WORDS > 1) ? $clog2(WR_WORDS) : 1;
    localparam int SW       = $clog2(WORD_BITS);

    localparam logic [LI_W-1:0] LAST_PTR  = LI_W'(ROW_WORDS - 1);
    localparam logic [CW-1:0]   LAST_BASE = CW'((ROW_WORDS - 1) * WORD_BITS);
    localparam logic [CW-1:0]   ROW_LEN   = CW'(ROW_BITS);
    localparam logic [CW-1:0]   WB_C      = CW'(WORD_BITS);

    logic                 dir_up_reg;
    logic [CW-1:0]        lim_reg;
    logic                 miss_reg;
    logic                 rd_active_reg;
    logic [LI_W-1:0]      rd_ptr_reg;
    logic [CW-1:0]        rd_base_reg;
    logic                 ev_live_reg;
    logic                 ev_last_reg;
    logic                 ev_inram_reg;
    logic [CW-1:0]        ev_base_reg;
    logic                 pend_found_reg;
    logic [BIDX_W-1:0]    pend_idx_reg;
    logic                 m_found_reg;
    logic [BIDX_W-1:0]    m_bit_index_reg;
    logic [WR_WORDS-1:0]  vld_reg;

    logic                 st_up;
    logic [CW-1:0]        st_lim;
    logic                 st_miss;
    logic [CW-1:0]        pos_ext;
    logic                 we;
    logic                 issue;
    logic                 at_end;
    logic                 rd_inram;
    logic [WORD_BITS-1:0] ram_q;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] masked;
    logic signed [CW:0]   off;
    logic signed [CW:0]   wbs;
    logic [SW-1:0]        shd;
    logic [ENC_W-1:0]     enc;
    logic                 hit;
    logic [CW-1:0]        hit_idx;
    logic                 conclude;

    // Query setup
    assign pos_ext = CW'(s_position);

    always_comb begin
        st_up   = 1'b1;
        st_lim  = '0;
        st_miss = 1'b0;
        unique case (s_op) inside
            OP_NEXT: begin
                st_lim = pos_ext + CW'(1);
            end
            OP_PREV: begin
                st_up   = 1'b0;
                st_lim  = pos_ext - CW'(1);
                st_miss = (s_position == '0);
            end
            OP_FIRST: begin
                st_lim = '0;
            end
            OP_LAST: begin
                st_up  = 1'b0;
                st_lim = ROW_LEN - CW'(1);
            end
            default: begin
                st_lim = '0;
            end
        endcase
        if (st_up && (st_lim >= ROW_LEN)) begin
            st_miss = 1'b1;
        end
    end

    // Row storage
    assign we = cmd.wr && (32'(s_word_index) < ROW_WORDS);

    brs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WR_WORDS),
        .AW    (AW)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (s_word_index[AW-1:0]),
        .wdata (s_word_data[WORD_BITS-1:0]),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (ram_q)
    );

    // Read side
    assign issue    = cmd.scan && rd_active_reg;
    assign at_end   = dir_up_reg ? (rd_ptr_reg == LAST_PTR) : (rd_ptr_reg == '0);
    assign rd_inram = ({1'b0, rd_ptr_reg} < (LI_W + 1)'(WR_WORDS))
                      && vld_reg[rd_ptr_reg[AW-1:0]];

    // Evaluate side
    assign word = ev_inram_reg ? ram_q : '0;
    assign off  = $signed({1'b0, lim_reg}) - $signed({1'b0, ev_base_reg});
    assign wbs  = $signed({1'b0, WB_C});
    assign shd  = SW'(WORD_BITS - 1) - off[SW-1:0];

    always_comb begin
        if (dir_up_reg) begin
            if (off <= 0) begin
                mask = '1;
            end else if (off >= wbs) begin
                mask = '0;
            end else begin
                mask = {WORD_BITS{1'b1}} << off[SW-1:0];
            end
        end else begin
            if (off < 0) begin
                mask = '0;
            end else if (off >= wbs - 1) begin
                mask = '1;
            end else begin
                mask = {WORD_BITS{1'b1}} >> shd;
            end
        end
    end

    assign masked   = word & mask;
    assign hit      = (masked != '0);
    assign enc      = dir_up_reg ? low_one(MAX_WB'(masked)) : high_one(MAX_WB'(masked));
    assign hit_idx  = ev_base_reg + CW'(enc);
    assign conclude = cmd.scan && ev_live_reg && (hit || ev_last_reg);

    assign sts.done = miss_reg || (ev_live_reg && (hit || ev_last_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            miss_reg      <= 1'b0;
            rd_active_reg <= 1'b0;
            ev_live_reg   <= 1'b0;
        end else begin
            if (we) begin
                vld_reg[s_word_index[AW-1:0]] <= 1'b1;
            end
            if (cmd.start) begin
                miss_reg      <= st_miss;
                rd_active_reg <= !st_miss;
                ev_live_reg   <= 1'b0;
            end else if (cmd.scan) begin
                ev_live_reg <= issue;
                if (issue && at_end) begin
                    rd_active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            dir_up_reg     <= st_up;
            lim_reg        <= st_lim;
            rd_ptr_reg     <= st_up ? '0 : LAST_PTR;
            rd_base_reg    <= st_up ? '0 : LAST_BASE;
            pend_found_reg <= 1'b0;
            pend_idx_reg   <= '0;
        end else begin
            if (issue) begin
                ev_base_reg  <= rd_base_reg;
                ev_last_reg  <= at_end;
                ev_inram_reg <= rd_inram;
                if (!at_end) begin
                    if (dir_up_reg) begin
                        rd_ptr_reg  <= rd_ptr_reg + LI_W'(1);
                        rd_base_reg <= rd_base_reg + WB_C;
                    end else begin
                        rd_ptr_reg  <= rd_ptr_reg - LI_W'(1);
                        rd_base_reg <= rd_base_reg - WB_C;
                    end
                end
            end
            if (conclude) begin
                pend_found_reg <= hit;
                pend_idx_reg   <= hit ? hit_idx[BIDX_W-1:0] : '0;
            end
        end
        if (cmd.load_out) begin
            m_found_reg     <= pend_found_reg;
            m_bit_index_reg <= pend_idx_reg;
        end
    end

    assign m_found     = m_found_reg;
    assign m_bit_index = m_bit_index_reg;

    a_ptr_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_active_reg |-> ({1'b0, rd_ptr_reg} < (LI_W + 1)'(ROW_WORDS)))
        else $error("scan pointer left the row");

    a_miss_zero_index: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(cmd.load_out) && !m_found_reg) |-> (m_bit_index_reg == '0))
        else $error("not-found result carries a nonzero index");

endmodule
